FILE: rtl/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Types, constants and small calendar functions shared by the calendar clock
// and its checker.
// ----------------------------------------------------------------------------
package cca_pkg;

    // Command codes carried in the op field
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SET_TIME  = 2'd1;
    localparam logic [1:0] OP_SET_ALARM = 2'd2;
    localparam logic [1:0] OP_STOP      = 2'd3;

    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [3:0]  MONTH_MAX   = 4'd12;
    localparam logic [4:0]  HOUR_MAX    = 5'd23;
    localparam logic [5:0]  MINUTE_MAX  = 6'd59;
    localparam logic [5:0]  SECOND_MAX  = 6'd59;
    localparam logic [6:0]  REM_MAX     = 7'd99;
    localparam logic [7:0]  TPS_RESET   = 8'd20;

    // Reset date: 21 January 2020, midnight
    localparam logic [13:0] YEAR_RESET  = 14'd2020;
    localparam logic [6:0]  CENT_RESET  = 7'd20;
    localparam logic [6:0]  REM_RESET   = 7'd20;
    localparam logic [3:0]  MONTH_RESET = 4'd1;
    localparam logic [4:0]  DAY_RESET   = 5'd21;

    // Century split of a year up to 9999: floor(y * 5243 / 2^19) == floor(y / 100)
    localparam logic [12:0] CENT_RECIP  = 13'd5243;
    localparam int          CENT_SHIFT  = 19;

    typedef struct packed {
        logic [1:0]  op;
        logic [13:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } cmd_t;

    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [2:0]  weekday;
        logic        buzzer_on;
        logic        alarm_armed;
    } res_t;

    // Clock state after one transaction, before the weekday is worked out
    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  cent;
        logic [6:0]  rem;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        buzzer;
        logic        armed;
    } snap_t;

    // The year is held as century and year within century.
    function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] rem);
        if (rem != 7'd0)
            return rem[1:0] == 2'd0;
        return cent[1:0] == 2'd0;
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(13 * (m + 1) / 5), January and February counted as months 13 and 14
    function automatic logic [5:0] month_term(input logic [3:0] month);
        logic [5:0] t;
        case (month)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // Zeller's congruence on the year plus 400, which is a whole number of weeks.
    function automatic logic [2:0] weekday_of(input logic [6:0] cent, input logic [6:0] rem,
                                              input logic [3:0] month, input logic [4:0] day);
        logic [6:0] j;
        logic [6:0] k;
        logic [9:0] sum;
        logic [4:0] fold1;
        logic [3:0] fold2;
        if (month < 4'd3) begin
            // January and February belong to the previous year
            if (rem == 7'd0) begin
                j = 7'(cent + 7'd3);
                k = REM_MAX;
            end else begin
                j = 7'(cent + 7'd4);
                k = 7'(rem - 7'd1);
            end
        end else begin
            j = 7'(cent + 7'd4);
            k = rem;
        end
        sum = 10'(k) + 10'(k[6:2]) + 10'(j[6:2]) + {1'b0, j, 2'b00} + 10'(j)
              + 10'(month_term(month)) + 10'(day) + 10'd6;
        // Eight is one modulo seven, so the octal digits can be summed.
        fold1 = 5'(sum[9]) + 5'(sum[8:6]) + 5'(sum[5:3]) + 5'(sum[2:0]);
        fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
        return (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    endfunction

endpackage

FILE: rtl/calendar_clock_with_alarm.sv
// ----------------------------------------------------------------------------
// calendar_clock_with_alarm
// Real-time clock and calendar with a one-shot alarm. Every command
// transaction (tick, set time, set alarm, stop buzzer) yields one result
// transaction with the date, time, weekday and alarm flags after it. The
// block takes one transaction per clock cycle while the result side does not
// stall, and has three register stages: the command register, the clock
// state update with its snapshot register, and the weekday stage feeding the
// result register. cmd_stall follows res_stall combinationally once all three
// stages hold data. The ticks_per_second register is always ready and should
// only be written while no transaction is in flight; a value of zero means
// 256 ticks.
// ----------------------------------------------------------------------------
module calendar_clock_with_alarm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  cca_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output cca_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);

    // Pipeline control
    logic res_load, s2_load, s1_load, s1_move;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic res_valid_reg, res_valid_next;

    // Stage payloads
    cca_pkg::cmd_t  s1_cmd_reg;
    logic [6:0]     s1_cent_reg, s1_rem_reg;
    cca_pkg::snap_t s2_snap_reg;
    cca_pkg::res_t  res_reg;

    // Century split of the incoming year
    logic [13:0] in_year_cl;
    logic [26:0] in_prod;
    logic [6:0]  in_cent;
    logic [13:0] in_rem_wide;

    // Clock state
    logic [7:0]  tps_reg;
    logic [7:0]  tick_reg, tick_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  cent_reg, cent_next;
    logic [6:0]  rem_reg, rem_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [13:0] al_year_reg, al_year_next;
    logic [3:0]  al_month_reg, al_month_next;
    logic [4:0]  al_day_reg, al_day_next;
    logic [4:0]  al_hour_reg, al_hour_next;
    logic [5:0]  al_minute_reg, al_minute_next;
    logic        armed_reg, armed_next;
    logic        buzzer_reg, buzzer_next;

    // Update terms
    logic [8:0]  tick_limit, tick_inc;
    logic        tick_wrap;
    logic [4:0]  cur_len;
    logic        sec_wrap, min_wrap, hr_wrap, day_wrap, mon_wrap;
    logic [3:0]  set_month_cl;
    logic [4:0]  set_len;

    assign res_load  = !res_valid_reg || !res_stall;
    assign s2_load   = !s2_valid_reg || res_load;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign s1_move   = s1_valid_reg && s2_load;
    assign cmd_stall = !s1_load;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign s1_valid_next  = s1_load ? cmd_valid : s1_valid_reg;
    assign s2_valid_next  = s2_load ? s1_valid_reg : s2_valid_reg;
    assign res_valid_next = res_load ? s2_valid_reg : res_valid_reg;

    assign in_year_cl  = (cmd.set_year > cca_pkg::YEAR_MAX) ? cca_pkg::YEAR_MAX : cmd.set_year;
    assign in_prod     = 27'(in_year_cl) * 27'(cca_pkg::CENT_RECIP);
    assign in_cent     = in_prod[cca_pkg::CENT_SHIFT +: 7];
    assign in_rem_wide = 14'(in_year_cl - 14'(in_cent) * 14'd100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && cmd_valid)
        begin
            s1_cmd_reg  <= cmd;
            s1_cent_reg <= in_cent;
            s1_rem_reg  <= in_rem_wide[6:0];
        end
        if (s1_move)
        begin
            s2_snap_reg.year   <= year_next;
            s2_snap_reg.cent   <= cent_next;
            s2_snap_reg.rem    <= rem_next;
            s2_snap_reg.month  <= month_next;
            s2_snap_reg.day    <= day_next;
            s2_snap_reg.hour   <= hour_next;
            s2_snap_reg.minute <= minute_next;
            s2_snap_reg.second <= second_next;
            s2_snap_reg.buzzer <= buzzer_next;
            s2_snap_reg.armed  <= armed_next;
        end
        if (res_load && s2_valid_reg)
        begin
            res_reg.cur_year    <= s2_snap_reg.year;
            res_reg.cur_month   <= s2_snap_reg.month;
            res_reg.cur_day     <= s2_snap_reg.day;
            res_reg.cur_hour    <= s2_snap_reg.hour;
            res_reg.cur_minute  <= s2_snap_reg.minute;
            res_reg.cur_second  <= s2_snap_reg.second;
            res_reg.weekday     <= cca_pkg::weekday_of(s2_snap_reg.cent, s2_snap_reg.rem,
                                                       s2_snap_reg.month, s2_snap_reg.day);
            res_reg.buzzer_on   <= s2_snap_reg.buzzer;
            res_reg.alarm_armed <= s2_snap_reg.armed;
        end
    end

    // Carry chain; the stored time is always within range, so each carry is
    // a compare against the top value.
    assign tick_limit = (tps_reg == 8'd0) ? 9'd256 : {1'b0, tps_reg};
    assign tick_inc   = {1'b0, tick_reg} + 9'd1;
    assign tick_wrap  = tick_inc >= tick_limit;
    assign cur_len    = cca_pkg::days_in(month_reg, cca_pkg::is_leap(cent_reg, rem_reg));
    assign sec_wrap   = second_reg == cca_pkg::SECOND_MAX;
    assign min_wrap   = sec_wrap && (minute_reg == cca_pkg::MINUTE_MAX);
    assign hr_wrap    = min_wrap && (hour_reg == cca_pkg::HOUR_MAX);
    assign day_wrap   = hr_wrap && (day_reg >= cur_len);
    assign mon_wrap   = day_wrap && (month_reg == cca_pkg::MONTH_MAX);

    assign set_month_cl = (s1_cmd_reg.set_month == 4'd0) ? 4'd1 :
                          (s1_cmd_reg.set_month > cca_pkg::MONTH_MAX) ? cca_pkg::MONTH_MAX :
                          s1_cmd_reg.set_month;
    assign set_len      = cca_pkg::days_in(set_month_cl,
                                           cca_pkg::is_leap(s1_cent_reg, s1_rem_reg));

    always_comb
    begin
        tick_next      = tick_reg;
        year_next      = year_reg;
        cent_next      = cent_reg;
        rem_next       = rem_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        al_year_next   = al_year_reg;
        al_month_next  = al_month_reg;
        al_day_next    = al_day_reg;
        al_hour_next   = al_hour_reg;
        al_minute_next = al_minute_reg;
        armed_next     = armed_reg;
        buzzer_next    = buzzer_reg;
        if (s1_move)
        begin
            case (s1_cmd_reg.op)
                cca_pkg::OP_TICK:
                begin
                    if (tick_wrap)
                    begin
                        tick_next   = 8'd0;
                        second_next = sec_wrap ? 6'd0 : 6'(second_reg + 6'd1);
                        if (sec_wrap)
                            minute_next = min_wrap ? 6'd0 : 6'(minute_reg + 6'd1);
                        if (min_wrap)
                            hour_next = hr_wrap ? 5'd0 : 5'(hour_reg + 5'd1);
                        if (hr_wrap)
                            day_next = day_wrap ? 5'd1 : 5'(day_reg + 5'd1);
                        if (day_wrap)
                            month_next = mon_wrap ? 4'd1 : 4'(month_reg + 4'd1);
                        if (mon_wrap)
                        begin
                            if (year_reg == cca_pkg::YEAR_MAX)
                            begin
                                year_next = 14'd0;
                                cent_next = 7'd0;
                                rem_next  = 7'd0;
                            end
                            else
                            begin
                                year_next = 14'(year_reg + 14'd1);
                                if (rem_reg == cca_pkg::REM_MAX)
                                begin
                                    rem_next  = 7'd0;
                                    cent_next = 7'(cent_reg + 7'd1);
                                end
                                else
                                begin
                                    rem_next = 7'(rem_reg + 7'd1);
                                end
                            end
                        end
                        // The alarm is looked at only when the minute has moved on
                        if (sec_wrap && armed_reg &&
                            al_year_reg == year_next && al_month_reg == month_next &&
                            al_day_reg == day_next && al_hour_reg == hour_next &&
                            al_minute_reg == minute_next)
                        begin
                            buzzer_next = 1'b1;
                            armed_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc[7:0];
                    end
                end
                cca_pkg::OP_SET_TIME:
                begin
                    year_next  = (s1_cmd_reg.set_year > cca_pkg::YEAR_MAX) ?
                                 cca_pkg::YEAR_MAX : s1_cmd_reg.set_year;
                    cent_next  = s1_cent_reg;
                    rem_next   = s1_rem_reg;
                    month_next = set_month_cl;
                    day_next   = (s1_cmd_reg.set_day == 5'd0) ? 5'd1 :
                                 (s1_cmd_reg.set_day > set_len) ? set_len : s1_cmd_reg.set_day;
                    hour_next  = (s1_cmd_reg.set_hour > cca_pkg::HOUR_MAX) ?
                                 cca_pkg::HOUR_MAX : s1_cmd_reg.set_hour;
                    minute_next = (s1_cmd_reg.set_minute > cca_pkg::MINUTE_MAX) ?
                                  cca_pkg::MINUTE_MAX : s1_cmd_reg.set_minute;
                    second_next = (s1_cmd_reg.set_second > cca_pkg::SECOND_MAX) ?
                                  cca_pkg::SECOND_MAX : s1_cmd_reg.set_second;
                end
                cca_pkg::OP_SET_ALARM:
                begin
                    al_year_next   = s1_cmd_reg.set_year;
                    al_month_next  = s1_cmd_reg.set_month;
                    al_day_next    = s1_cmd_reg.set_day;
                    al_hour_next   = s1_cmd_reg.set_hour;
                    al_minute_next = s1_cmd_reg.set_minute;
                    armed_next     = 1'b1;
                end
                cca_pkg::OP_STOP:
                begin
                    buzzer_next = 1'b0;
                end
                default:
                begin
                    buzzer_next = buzzer_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg       <= cca_pkg::TPS_RESET;
            tick_reg      <= 8'd0;
            year_reg      <= cca_pkg::YEAR_RESET;
            cent_reg      <= cca_pkg::CENT_RESET;
            rem_reg       <= cca_pkg::REM_RESET;
            month_reg     <= cca_pkg::MONTH_RESET;
            day_reg       <= cca_pkg::DAY_RESET;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            second_reg    <= 6'd0;
            al_year_reg   <= 14'd0;
            al_month_reg  <= 4'd0;
            al_day_reg    <= 5'd0;
            al_hour_reg   <= 5'd0;
            al_minute_reg <= 6'd0;
            armed_reg     <= 1'b0;
            buzzer_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                tps_reg <= cfg_data;
            tick_reg      <= tick_next;
            year_reg      <= year_next;
            cent_reg      <= cent_next;
            rem_reg       <= rem_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            al_year_reg   <= al_year_next;
            al_month_reg  <= al_month_next;
            al_day_reg    <= al_day_next;
            al_hour_reg   <= al_hour_next;
            al_minute_reg <= al_minute_next;
            armed_reg     <= armed_next;
            buzzer_reg    <= buzzer_next;
        end
    end

endmodule

FILE: rtl/cca_checker.sv
// ----------------------------------------------------------------------------
// cca_checker
// Port-level checks on the calendar clock's result stream.
// ----------------------------------------------------------------------------
module cca_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_stall,
    input cca_pkg::res_t res
);

    // Alarm flag of the previous delivered result
    logic seen_reg;
    logic prev_armed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_armed_reg <= 1'b0;
        end
        else if (res_valid && !res_stall)
        begin
            seen_reg       <= 1'b1;
            prev_armed_reg <= res.alarm_armed;
        end
    end

    // A stalled result transaction holds its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Every date and time field shown stays within its own range.
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.cur_year <= 14'd9999 && res.cur_month >= 4'd1 &&
                      res.cur_month <= 4'd12 && res.cur_day >= 5'd1 &&
                      res.cur_day <= 5'd31 && res.cur_hour <= 5'd23 &&
                      res.cur_minute <= 6'd59 && res.cur_second <= 6'd59)
        else $error("date or time out of range");

    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.weekday <= 3'd6)
        else $error("weekday out of range");

    // The alarm only disarms by firing, which turns the buzzer on.
    a_disarm_fires: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_reg && prev_armed_reg && !res.alarm_armed |-> res.buzzer_on)
        else $error("alarm disarmed without sounding the buzzer");

endmodule

bind calendar_clock_with_alarm cca_checker u_cca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calendar clock. Directed commands cover carries,
// year wrap, leap rules, clamping on set time and alarm behaviour. Random
// scenarios before and after them set a date near a boundary, usually arm an
// alarm on the next minute and tick through it under several prescale settings.
// A scoreboard predicts every result transaction and compares it field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT = 5000;

    class calendar_scoreboard;
        int   rate;
        int   prescale;
        int   yr, mon, dom, hr, mins, secs;
        int   al_yr, al_mon, al_dom, al_hr, al_min;
        bit   armed, buzzing;
        cca_pkg::res_t expected_q[$];
        int   errors;

        function new();
            rate     = cca_pkg::TPS_RESET;
            prescale = 0;
            yr       = cca_pkg::YEAR_RESET;
            mon      = cca_pkg::MONTH_RESET;
            dom      = cca_pkg::DAY_RESET;
            hr       = 0;
            mins     = 0;
            secs     = 0;
            al_yr    = 0;
            al_mon   = 0;
            al_dom   = 0;
            al_hr    = 0;
            al_min   = 0;
            armed    = 1'b0;
            buzzing  = 1'b0;
            errors   = 0;
        endfunction

        static function int month_days(int y, int m);
            bit leap;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m < 1 || m > 12)
                return 31;
            if (m == 2)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // Zeller's congruence, shifted by 400 years so nothing goes negative.
        static function int day_of_week(int y, int m, int d);
            int yy;
            int mm;
            int j;
            int k;
            yy = y + 400;
            mm = m;
            if (mm < 3)
            begin
                mm += 12;
                yy -= 1;
            end
            j = yy / 100;
            k = yy % 100;
            return (k + k / 4 + j / 4 + 5 * j + (13 * (mm + 1)) / 5 + d + 6) % 7;
        endfunction

        function void set_rate(logic [7:0] v);
            rate = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void step_second();
            bit minute_rolled;
            minute_rolled = 1'b0;
            secs++;
            if (secs >= 60)
            begin
                secs = 0;
                mins++;
                minute_rolled = 1'b1;
            end
            if (mins >= 60)
            begin
                mins = 0;
                hr++;
            end
            if (hr >= 24)
            begin
                hr = 0;
                dom++;
            end
            if (dom > month_days(yr, mon))
            begin
                dom = 1;
                mon++;
            end
            if (mon > 12)
            begin
                mon = 1;
                yr++;
                if (yr > 9999)
                    yr = 0;
            end
            if (minute_rolled && armed && al_yr == yr && al_mon == mon && al_dom == dom &&
                al_hr == hr && al_min == mins)
            begin
                buzzing = 1'b1;
                armed   = 1'b0;
            end
        endfunction

        function void note_command(cca_pkg::cmd_t c);
            int   limit;
            int   len;
            cca_pkg::res_t r;
            case (c.op)
                cca_pkg::OP_TICK:
                begin
                    limit = (rate == 0) ? 256 : rate;
                    if (prescale + 1 >= limit)
                    begin
                        prescale = 0;
                        step_second();
                    end
                    else
                        prescale++;
                end
                cca_pkg::OP_SET_TIME:
                begin
                    yr   = (c.set_year > cca_pkg::YEAR_MAX) ?
                           int'(cca_pkg::YEAR_MAX) : int'(c.set_year);
                    mon  = (c.set_month == 4'd0) ? 1 :
                           ((c.set_month > cca_pkg::MONTH_MAX) ?
                            int'(cca_pkg::MONTH_MAX) : int'(c.set_month));
                    len  = month_days(yr, mon);
                    dom  = (c.set_day == 5'd0) ? 1 : ((c.set_day > len) ? len : int'(c.set_day));
                    hr   = (c.set_hour > cca_pkg::HOUR_MAX) ?
                           int'(cca_pkg::HOUR_MAX) : int'(c.set_hour);
                    mins = (c.set_minute > cca_pkg::MINUTE_MAX) ?
                           int'(cca_pkg::MINUTE_MAX) : int'(c.set_minute);
                    secs = (c.set_second > cca_pkg::SECOND_MAX) ?
                           int'(cca_pkg::SECOND_MAX) : int'(c.set_second);
                end
                cca_pkg::OP_SET_ALARM:
                begin
                    al_yr  = c.set_year;
                    al_mon = c.set_month;
                    al_dom = c.set_day;
                    al_hr  = c.set_hour;
                    al_min = c.set_minute;
                    armed  = 1'b1;
                end
                cca_pkg::OP_STOP:
                    buzzing = 1'b0;
                default:
                    buzzing = buzzing;
            endcase
            r.cur_year    = 14'(yr);
            r.cur_month   = 4'(mon);
            r.cur_day     = 5'(dom);
            r.cur_hour    = 5'(hr);
            r.cur_minute  = 6'(mins);
            r.cur_second  = 6'(secs);
            r.weekday     = 3'(day_of_week(yr, mon, dom));
            r.buzzer_on   = buzzing;
            r.alarm_armed = armed;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(cca_pkg::res_t got);
            cca_pkg::res_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.cur_year !== want.cur_year)
                report($sformatf("year %0d, expected %0d", got.cur_year, want.cur_year));
            if (got.cur_month !== want.cur_month)
                report($sformatf("month %0d, expected %0d", got.cur_month, want.cur_month));
            if (got.cur_day !== want.cur_day)
                report($sformatf("day %0d, expected %0d", got.cur_day, want.cur_day));
            if (got.cur_hour !== want.cur_hour)
                report($sformatf("hour %0d, expected %0d", got.cur_hour, want.cur_hour));
            if (got.cur_minute !== want.cur_minute)
                report($sformatf("minute %0d, expected %0d", got.cur_minute, want.cur_minute));
            if (got.cur_second !== want.cur_second)
                report($sformatf("second %0d, expected %0d", got.cur_second, want.cur_second));
            if (got.weekday !== want.weekday)
                report($sformatf("weekday %0d, expected %0d", got.weekday, want.weekday));
            if (got.buzzer_on !== want.buzzer_on)
                report($sformatf("buzzer %b, expected %b", got.buzzer_on, want.buzzer_on));
            if (got.alarm_armed !== want.alarm_armed)
                report($sformatf("armed %b, expected %b", got.alarm_armed, want.alarm_armed));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          cmd_valid;
    logic          cmd_stall;
    cca_pkg::cmd_t cmd;
    logic          res_valid;
    logic          res_stall;
    cca_pkg::res_t res;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [7:0]    cfg_data;

    calendar_scoreboard sb = new();

    int sent        = 0;
    int hold_cycles = 0;
    int idle_cycles = 0;
    bit send_calm   = 1'b0;
    bit send_burst  = 1'b0;
    bit recv_calm   = 1'b0;

    calendar_clock_with_alarm u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic cca_pkg::cmd_t make_cmd(logic [1:0] op, int y, int m, int d, int h,
                                               int mi, int s);
        cca_pkg::cmd_t c;
        c.op         = op;
        c.set_year   = 14'(y);
        c.set_month  = 4'(m);
        c.set_day    = 5'(d);
        c.set_hour   = 5'(h);
        c.set_minute = 6'(mi);
        c.set_second = 6'(s);
        return c;
    endfunction

    function automatic cca_pkg::cmd_t random_cmd();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(cca_pkg::cmd_t)-1:0];
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_cmd(input cca_pkg::cmd_t c);
        int n;
        if ($urandom_range(0, 15) == 0)
            send_calm = !send_calm;
        n = (send_calm || send_burst) ? 0 : $urandom_range(0, 12);
        if (n > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(negedge clk); while (cmd_stall);
        @(posedge clk);
        sb.note_command(c);
        sent++;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rate(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        sb.set_rate(v);
        cfg_valid <= 1'b0;
    endtask

    // Scenarios: set a date close to a carry, usually arm the alarm for the next
    // minute, then tick through it with a little noise mixed in.
    task automatic run_phase(input int count);
        int   stop_at;
        int   y, m, d, h, mi, s;
        int   ay, am, ad, ah, ami;
        int   eff;
        int   k;
        int   r;
        cca_pkg::cmd_t c;
        stop_at = sent + count;
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       y = 9999;
                    1:       y = 2000;
                    2:       y = 1900;
                    3:       y = 2024;
                    4:       y = 0;
                    default: y = $urandom_range(0, 9999);
                endcase
                m  = ($urandom_range(0, 2) == 0) ? 12 : (($urandom_range(0, 2) == 0) ? 2 :
                     $urandom_range(1, 12));
                d  = ($urandom_range(0, 1) == 0) ? calendar_scoreboard::month_days(y, m) :
                     $urandom_range(1, calendar_scoreboard::month_days(y, m));
                h  = ($urandom_range(0, 1) == 0) ? 23 : $urandom_range(0, 23);
                mi = ($urandom_range(0, 1) == 0) ? 59 : $urandom_range(0, 59);
                s  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : $urandom_range(50, 59);
                send_cmd(make_cmd(cca_pkg::OP_SET_TIME, y, m, d, h, mi, s));
                if ($urandom_range(0, 3) != 0)
                begin
                    ay  = y;
                    am  = m;
                    ad  = d;
                    ah  = h;
                    ami = mi + 1;
                    if (ami == 60)
                    begin
                        ami = 0;
                        ah++;
                        if (ah == 24)
                        begin
                            ah = 0;
                            ad++;
                            if (ad > calendar_scoreboard::month_days(ay, am))
                            begin
                                ad = 1;
                                am++;
                                if (am == 13)
                                begin
                                    am = 1;
                                    ay = (ay == 9999) ? 0 : ay + 1;
                                end
                            end
                        end
                    end
                    if ($urandom_range(0, 3) == 0)
                        ami = (ami + $urandom_range(1, 59)) % 60;
                    send_cmd(make_cmd(cca_pkg::OP_SET_ALARM, ay, am, ad, ah, ami,
                                      $urandom_range(0, 63)));
                end
            end
            eff = (sb.rate == 0) ? 256 : sb.rate;
            k   = $urandom_range(1, (61 - sb.secs) * eff + 4);
            if (k > 300)
                k = 300;
            if (k > stop_at - sent)
                k = stop_at - sent;
            repeat (k)
            begin
                r = $urandom_range(0, 15);
                c = random_cmd();
                if (r == 1)
                    c.op = cca_pkg::OP_STOP;
                else if (r != 0)
                    c.op = cca_pkg::OP_TICK;
                send_cmd(c);
            end
            if ($urandom_range(0, 1) == 0)
                send_cmd(make_cmd(cca_pkg::OP_STOP, 0, 0, 0, 0, 0, 0));
        end
    endtask

    // Result side: random stall before each transaction, or a long hold when asked.
    initial
    begin
        int n;
        res_stall <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_calm = !recv_calm;
                n = recv_calm ? 0 : $urandom_range(0, 12);
            end
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(negedge clk); while (!res_valid);
            @(posedge clk);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Prescale left at its reset value.
        run_phase(40);

        write_rate(8'd1);
        // Year wrap with an alarm waiting on the first minute of year zero.
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 9999, 12, 31, 23, 59, 59));
        send_cmd(make_cmd(cca_pkg::OP_SET_ALARM, 0, 1, 1, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_STOP, 0, 0, 0, 0, 0, 0));
        // Every field but the day beyond its range, then every field at zero.
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 16383, 15, 31, 31, 63, 63));
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 0, 0, 0, 0, 0, 0));
        // Leap rules: 2000 is leap, 1900 is not, 2024 is.
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 2000, 2, 31, 12, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 1900, 2, 29, 23, 59, 59));
        send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 2024, 2, 28, 23, 59, 59));
        send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        // An alarm that can never match stays armed through a minute change.
        send_cmd(make_cmd(cca_pkg::OP_SET_ALARM, 16383, 15, 31, 31, 63, 63));
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 2023, 12, 31, 23, 59, 58));
        send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        // Alarm fires, is re-armed while sounding, then silenced twice.
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 2024, 1, 1, 0, 0, 59));
        send_cmd(make_cmd(cca_pkg::OP_SET_ALARM, 2024, 1, 1, 0, 1, 0));
        send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_SET_ALARM, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_STOP, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_STOP, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(cca_pkg::OP_SET_TIME, 2021, 3, 15, 12, 34, 56));
        send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));

        // Largest nonzero prescale value; the count builds up for the next phase.
        write_rate(8'd255);
        run_phase(40);

        // Prescale now below the count. The result side holds off for a long
        // stretch while commands keep coming, so the pipeline backs up.
        write_rate(8'd1);
        send_burst  = 1'b1;
        hold_cycles = 200;
        repeat (24) send_cmd(make_cmd(cca_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
        send_burst = 1'b0;
        run_phase(210);

        // Zero means 256 ticks per second.
        write_rate(8'd0);
        run_phase(260);

        write_rate(8'd7);
        run_phase(60);

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
